@@ hw/rtl/fvm_pkg.sv @@
// ----------------------------------------------------------------------------
// fvm_pkg
// Shared constants, types and the arctangent table of the voltage modulator.
// ----------------------------------------------------------------------------
package fvm_pkg;

	localparam int ANGLE_BITS   = 12;
	localparam int DUTY_BITS    = 16;
	localparam int CORDIC_STEPS = 16;
	localparam int STEP_W       = $clog2(CORDIC_STEPS);
	localparam int SUP_W        = 14;
	localparam int PP_W         = 6;
	localparam int UQ_W         = 16;
	localparam int CX_W         = 34;
	localparam int Z_W          = 24;
	localparam int SC_W         = CX_W - 14;
	localparam int AL_W         = 33;
	localparam int K3_W         = 19;
	localparam int V_W          = 52;
	localparam int W_W          = V_W - (34 - DUTY_BITS);

	localparam logic [SUP_W-1:0]        SUPPLY_MAX   = SUP_W'(12400);
	localparam logic [SUP_W-1:0]        SUPPLY_RST   = SUP_W'(12000);
	localparam logic [PP_W-1:0]         POLES_RST    = PP_W'(7);
	localparam logic signed [CX_W-1:0]  CORDIC_X0    = CX_W'(652032874);
	localparam logic signed [CX_W-1:0]  ROUND_Q14    = CX_W'(8192);
	localparam logic signed [K3_W-1:0]  SQRT3_Q16    = K3_W'(113512);
	localparam logic signed [Z_W-1:0]   Z_RESID_MAX  = Z_W'(256);

	localparam logic [1:0] REG_SUPPLY  = 2'd0;
	localparam logic [1:0] REG_POLES   = 2'd1;
	localparam logic [1:0] REG_DIR     = 2'd2;
	localparam logic [1:0] REG_ZERO    = 2'd3;

	typedef struct packed {
		logic signed [CX_W-1:0] x;
		logic signed [CX_W-1:0] y;
		logic signed [Z_W-1:0]  z;
		logic [1:0]             quad;
		logic signed [UQ_W-1:0] u;
	} cordic_t;

	typedef struct packed {
		logic [SUP_W-1:0]     rem;
		logic [DUTY_BITS-1:0] w;
		logic                 sat;
	} div_lane_t;

	typedef div_lane_t [2:0] div_row_t;

	function automatic logic signed [Z_W-1:0] atan_turn(input logic [STEP_W-1:0] i);
		logic signed [Z_W-1:0] a;
		case (i)
			4'd0:    a = Z_W'(2097152);
			4'd1:    a = Z_W'(1238021);
			4'd2:    a = Z_W'(654136);
			4'd3:    a = Z_W'(332050);
			4'd4:    a = Z_W'(166669);
			4'd5:    a = Z_W'(83416);
			4'd6:    a = Z_W'(41718);
			4'd7:    a = Z_W'(20860);
			4'd8:    a = Z_W'(10430);
			4'd9:    a = Z_W'(5215);
			4'd10:   a = Z_W'(2608);
			4'd11:   a = Z_W'(1304);
			4'd12:   a = Z_W'(652);
			4'd13:   a = Z_W'(326);
			4'd14:   a = Z_W'(163);
			4'd15:   a = Z_W'(81);
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

@@ hw/rtl/fvm_cordic_cell.sv @@
// ----------------------------------------------------------------------------
// fvm_cordic_cell
// One rotation step of the sine/cosine chain, registered.
// ----------------------------------------------------------------------------
module fvm_cordic_cell (
	input  logic                           clk,
	input  logic                           ce,
	input  logic [fvm_pkg::STEP_W-1:0]     step,
	input  fvm_pkg::cordic_t               d,
	output fvm_pkg::cordic_t               q
);

	logic signed [fvm_pkg::CX_W-1:0] dx;
	logic signed [fvm_pkg::CX_W-1:0] dy;
	logic signed [fvm_pkg::Z_W-1:0]  at;
	fvm_pkg::cordic_t                nxt;

	assign dx = d.y >>> step;
	assign dy = d.x >>> step;
	assign at = fvm_pkg::atan_turn(step);

	always_comb begin
		nxt = d;
		if (!d.z[fvm_pkg::Z_W-1]) begin
			nxt.x = d.x - dx;
			nxt.y = d.y + dy;
			nxt.z = d.z - at;
		end else begin
			nxt.x = d.x + dx;
			nxt.y = d.y - dy;
			nxt.z = d.z + at;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			q <= nxt;
		end
	end

endmodule

@@ hw/rtl/fvm_div_cell.sv @@
// ----------------------------------------------------------------------------
// fvm_div_cell
// One restoring division step for the three phase lanes, registered.
// ----------------------------------------------------------------------------
module fvm_div_cell (
	input  logic                          clk,
	input  logic                          ce,
	input  logic [fvm_pkg::SUP_W-1:0]     sup,
	input  fvm_pkg::div_row_t             d,
	output fvm_pkg::div_row_t             q
);

	fvm_pkg::div_row_t nxt;

	always_comb begin
		logic [fvm_pkg::SUP_W:0] t;
		logic                    ge;
		nxt = d;
		for (int l = 0; l < 3; l++) begin
			t  = {d[l].rem, d[l].w[fvm_pkg::DUTY_BITS-1]};
			ge = (t >= {1'b0, sup});
			nxt[l].rem = ge ? fvm_pkg::SUP_W'(t - {1'b0, sup}) : t[fvm_pkg::SUP_W-1:0];
			nxt[l].w   = {d[l].w[fvm_pkg::DUTY_BITS-2:0], ge};
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			q <= nxt;
		end
	end

endmodule

@@ hw/rtl/foc_voltage_modulator_top.sv @@
// ----------------------------------------------------------------------------
// foc_voltage_modulator_top
// Quadrature voltage command and rotor angle to three sinusoidal PWM duties.
// ----------------------------------------------------------------------------
// Input stream s_*: one transaction carries uq_mv and mech_angle. Output
// stream m_*: one transaction carries duty_a, duty_b, duty_c per input.
// The APB port sets supply, pole pairs, direction and zero offset; write it
// only while no transaction is in flight.
// From input acceptance to m_tvalid a transaction passes one angle/clamp
// stage, 16 CORDIC cells, three Park/Clarke stages (two multiplier ranks),
// 16 restoring divider cells and the output register.
// Throughput is one transaction per cycle while the skid register is empty;
// the cell chain advances as a whole. A skid register behind the chain
// absorbs one result when the receiver stalls; the chain halts while the
// skid register is full and resumes as soon as it empties.
// Reset clears all valid flags and loads the register defaults (12000 mV,
// 7 pole pairs, forward direction, zero offset 0).
// ----------------------------------------------------------------------------
module foc_voltage_modulator_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // uq_mv[15:0], mech_angle[27:16], zero fill
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // duty_a[15:0], duty_b[31:16], duty_c[47:32]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int CS   = fvm_pkg::CORDIC_STEPS;
	localparam int DB   = fvm_pkg::DUTY_BITS;
	localparam int NSTG = 1 + CS + 3 + DB;
	localparam int P1   = CS + 1;
	localparam int P2   = CS + 2;
	localparam int P3   = CS + 3;

	logic [fvm_pkg::SUP_W-1:0]      supply_q;
	logic [fvm_pkg::PP_W-1:0]       poles_q;
	logic                           dir_q;
	logic [fvm_pkg::ANGLE_BITS-1:0] zero_q;
	logic [fvm_pkg::SUP_W-1:0]      sup_eff;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			supply_q <= fvm_pkg::SUPPLY_RST;
			poles_q  <= fvm_pkg::POLES_RST;
			dir_q    <= 1'b0;
			zero_q   <= '0;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				fvm_pkg::REG_SUPPLY: supply_q <= pwdata[fvm_pkg::SUP_W-1:0];
				fvm_pkg::REG_POLES:  poles_q  <= pwdata[fvm_pkg::PP_W-1:0];
				fvm_pkg::REG_DIR:    dir_q    <= pwdata[0];
				fvm_pkg::REG_ZERO:   zero_q   <= pwdata[fvm_pkg::ANGLE_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			fvm_pkg::REG_SUPPLY: prdata = 32'(supply_q);
			fvm_pkg::REG_POLES:  prdata = 32'(poles_q);
			fvm_pkg::REG_DIR:    prdata = 32'(dir_q);
			fvm_pkg::REG_ZERO:   prdata = 32'(zero_q);
			default:             prdata = '0;
		endcase
	end

	always_comb begin
		if (supply_q == '0) begin
			sup_eff = fvm_pkg::SUP_W'(1);
		end else if (supply_q > fvm_pkg::SUPPLY_MAX) begin
			sup_eff = fvm_pkg::SUPPLY_MAX;
		end else begin
			sup_eff = supply_q;
		end
	end

	// pipeline control
	logic [NSTG-1:0] v_q;
	logic            en;
	logic            skid_v_q;
	logic            out_v_q;

	assign en       = !skid_v_q;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[NSTG-2:0], s_tvalid};
		end
	end

	// front stage: command clamp and electrical angle
	logic signed [fvm_pkg::UQ_W-1:0]   uq;
	logic [fvm_pkg::ANGLE_BITS-1:0]    mech;
	logic signed [fvm_pkg::UQ_W:0]     un;
	logic signed [fvm_pkg::UQ_W+1:0]   u2;
	logic signed [fvm_pkg::UQ_W+1:0]   sup_s;
	logic signed [fvm_pkg::UQ_W-1:0]   uc;
	logic [fvm_pkg::PP_W+fvm_pkg::ANGLE_BITS-1:0] prod;
	logic [fvm_pkg::ANGLE_BITS-1:0]    pa;
	logic [fvm_pkg::ANGLE_BITS-1:0]    elec;
	fvm_pkg::cordic_t                  c0;
	fvm_pkg::cordic_t                  cr [0:CS];

	assign uq    = s_tdata[15:0];
	assign mech  = s_tdata[16 +: fvm_pkg::ANGLE_BITS];
	assign un    = dir_q ? -(fvm_pkg::UQ_W+1)'(uq) : (fvm_pkg::UQ_W+1)'(uq);
	assign u2    = {un, 1'b0};
	assign sup_s = $signed((fvm_pkg::UQ_W+2)'(sup_eff));
	assign prod  = poles_q * mech;
	assign pa    = dir_q ? fvm_pkg::ANGLE_BITS'(-prod[fvm_pkg::ANGLE_BITS-1:0])
	                     : prod[fvm_pkg::ANGLE_BITS-1:0];
	assign elec  = pa - zero_q;

	always_comb begin
		if (u2 > sup_s) begin
			uc = fvm_pkg::UQ_W'(sup_s);
		end else if (u2 < -sup_s) begin
			uc = fvm_pkg::UQ_W'(-sup_s);
		end else begin
			uc = fvm_pkg::UQ_W'(u2);
		end
		c0.x    = fvm_pkg::CORDIC_X0;
		c0.y    = '0;
		c0.z    = fvm_pkg::Z_W'(elec[fvm_pkg::ANGLE_BITS-3:0]) << (24 - fvm_pkg::ANGLE_BITS);
		c0.quad = elec[fvm_pkg::ANGLE_BITS-1 -: 2];
		c0.u    = uc;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cr[0] <= c0;
		end
	end

	for (genvar i = 0; i < CS; i++) begin : g_cordic
		fvm_cordic_cell u_cell (
			.clk  (clk),
			.ce   (en),
			.step (fvm_pkg::STEP_W'(i)),
			.d    (cr[i]),
			.q    (cr[i+1])
		);
	end

	// inverse Park
	logic signed [fvm_pkg::CX_W-1:0] xr;
	logic signed [fvm_pkg::CX_W-1:0] yr;
	logic signed [fvm_pkg::SC_W-1:0] cq;
	logic signed [fvm_pkg::SC_W-1:0] sq;
	logic signed [fvm_pkg::SC_W-1:0] sn;
	logic signed [fvm_pkg::SC_W-1:0] cs;
	logic signed [fvm_pkg::AL_W-1:0] al_s1;
	logic signed [fvm_pkg::AL_W-1:0] be_s1;
	logic signed [fvm_pkg::AL_W-1:0] al_s2;
	logic signed [fvm_pkg::V_W-1:0]  m_s2;

	assign xr = cr[CS].x + fvm_pkg::ROUND_Q14;
	assign yr = cr[CS].y + fvm_pkg::ROUND_Q14;
	assign cq = fvm_pkg::SC_W'(xr >>> 14);
	assign sq = fvm_pkg::SC_W'(yr >>> 14);

	always_comb begin
		case (cr[CS].quad)
			2'd0:    begin cs = cq;  sn = sq;  end
			2'd1:    begin cs = -sq; sn = cq;  end
			2'd2:    begin cs = -cq; sn = -sq; end
			default: begin cs = sq;  sn = -cq; end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			al_s1 <= fvm_pkg::AL_W'(-(cr[CS].u * sn));
			be_s1 <= fvm_pkg::AL_W'(cr[CS].u * cs);
			al_s2 <= al_s1;
			m_s2  <= fvm_pkg::V_W'(fvm_pkg::SQRT3_Q16 * be_s1);
		end
	end

	// inverse Clarke, offset, clamp, divider setup
	logic signed [fvm_pkg::V_W-1:0] mid;
	logic signed [fvm_pkg::V_W-1:0] al_w;
	logic signed [fvm_pkg::V_W-1:0] va;
	logic signed [fvm_pkg::V_W-1:0] vb;
	logic signed [fvm_pkg::V_W-1:0] vc;
	fvm_pkg::div_row_t              dr0;
	fvm_pkg::div_row_t              dr [0:DB];

	function automatic fvm_pkg::div_lane_t mk_lane(input logic signed [fvm_pkg::V_W-1:0] v,
	                                               input logic [fvm_pkg::SUP_W-1:0] sup);
		logic [fvm_pkg::W_W-1:0] w;
		logic                    neg;
		logic                    sat;
		fvm_pkg::div_lane_t      ln;
		w   = fvm_pkg::W_W'(v >>> (34 - fvm_pkg::DUTY_BITS));
		neg = v[fvm_pkg::V_W-1];
		sat = !neg && (w >= (fvm_pkg::W_W'(sup) << fvm_pkg::DUTY_BITS));
		ln.sat = sat;
		ln.rem = (neg || sat) ? '0 : w[fvm_pkg::DUTY_BITS +: fvm_pkg::SUP_W];
		ln.w   = (neg || sat) ? '0 : w[fvm_pkg::DUTY_BITS-1:0];
		return ln;
	endfunction

	assign mid  = fvm_pkg::V_W'(sup_eff) <<< 33;
	assign al_w = fvm_pkg::V_W'(al_s2);
	assign va   = (al_w <<< 17) + mid;
	assign vb   = m_s2 - (al_w <<< 16) + mid;
	assign vc   = -(al_w <<< 16) - m_s2 + mid;

	always_comb begin
		dr0[0] = mk_lane(va, sup_eff);
		dr0[1] = mk_lane(vb, sup_eff);
		dr0[2] = mk_lane(vc, sup_eff);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dr[0] <= dr0;
		end
	end

	for (genvar k = 0; k < DB; k++) begin : g_div
		fvm_div_cell u_cell (
			.clk (clk),
			.ce  (en),
			.sup (sup_eff),
			.d   (dr[k]),
			.q   (dr[k+1])
		);
	end

	// output register with skid
	logic [47:0] pipe_d;
	logic [47:0] skid_d_q;
	logic [47:0] out_d_q;
	logic        leaving;
	logic        out_free;

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			pipe_d[16*l +: 16] = 16'(dr[DB][l].sat ? {DB{1'b1}} : dr[DB][l].w);
		end
	end

	assign leaving  = en && v_q[NSTG-1];
	assign out_free = !out_v_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (out_free) begin
			out_v_q  <= skid_v_q || leaving;
			skid_v_q <= 1'b0;
		end else if (leaving) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_d_q <= skid_v_q ? skid_d_q : pipe_d;
		end else if (leaving) begin
			skid_d_q <= pipe_d;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_d_q;

`ifndef SYNTHESIS
	a_accept_fills_front: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> v_q[0])
		else $error("accepted transaction did not enter the front stage");

	a_cordic_converged: assert property (@(posedge clk) disable iff (!arst_n)
		v_q[CS] |-> (cr[CS].z <= fvm_pkg::Z_RESID_MAX && cr[CS].z >= -fvm_pkg::Z_RESID_MAX))
		else $error("CORDIC residual angle too large");

	a_div_remainder: assert property (@(posedge clk) disable iff (!arst_n)
		v_q[NSTG-1] |-> (dr[DB][0].rem < sup_eff && dr[DB][1].rem < sup_eff
		                 && dr[DB][2].rem < sup_eff))
		else $error("divider remainder not below supply");

	a_skid_only_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid register holds data while output register is empty");
`endif

endmodule

@@ test/foc_voltage_modulator_top_tb.sv @@
// ----------------------------------------------------------------------------
// foc_voltage_modulator_top_tb
// Stream test of the voltage modulator against a bit-exact duty predictor.
// Commands and angles go in through the s_* stream and duty triples are
// compared in order with predicted values. The register settings change
// between phases, and the sender and receiver idle at varying rates,
// including one long receiver hold-off.
// ----------------------------------------------------------------------------
module foc_voltage_modulator_top_tb;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	foc_voltage_modulator_top dut (.*);

	typedef struct packed {
		logic signed [15:0] uq;
		logic [11:0]        ang;
	} cmd_t;

	typedef struct packed {
		logic [15:0] c;
		logic [15:0] b;
		logic [15:0] a;
	} duty_t;

	cmd_t  pending_cmds[$];
	duty_t duty_expected[$];
	int    mismatches;
	int    send_idle_pct;
	int    recv_idle_pct;
	int    hold_cycles;

	longint unsigned mod_supply;
	longint unsigned mod_poles;
	longint unsigned mod_dir;
	longint unsigned mod_zero;

	localparam longint ATAN24[16] = '{2097152, 1238021, 654136, 332050, 166669, 83416,
		41718, 20860, 10430, 5215, 2608, 1304, 652, 326, 163, 81};

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic longint asr_floor(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint phase_duty(longint v, longint sup);
		longint full;
		longint d;
		full = sup <<< 34;
		if (v < 0) v = 0;
		if (v > full) v = full;
		d = v / (sup <<< 18);
		return (d > 65535) ? 65535 : d;
	endfunction

	function automatic duty_t predict_duty(cmd_t cmd);
		longint sup, u, x, y, z, dx, dy, c, s, sn, cs, al, be, mid;
		longint unsigned prod, elec, ang;
		duty_t r;
		sup = mod_supply;
		if (sup < 1) sup = 1;
		if (sup > 12400) sup = 12400;
		u = longint'(cmd.uq);
		if (mod_dir != 0) u = -u;
		u = u * 2;
		if (u > sup) u = sup;
		if (u < -sup) u = -sup;
		prod = (mod_poles * cmd.ang) & 64'hFFF;
		if (mod_dir != 0) prod = (0 - prod) & 64'hFFF;
		elec = (prod - mod_zero) & 64'hFFF;
		ang = elec << 12;
		z = longint'(ang & 64'h3FFFFF);
		x = 652032874;
		y = 0;
		for (int i = 0; i < 16; i++) begin
			dx = asr_floor(y, i);
			dy = asr_floor(x, i);
			if (z >= 0) begin
				x -= dx; y += dy; z -= ATAN24[i];
			end else begin
				x += dx; y -= dy; z += ATAN24[i];
			end
		end
		c = asr_floor(x + 8192, 14);
		s = asr_floor(y + 8192, 14);
		case ((ang >> 22) & 3)
			0: begin cs = c;  sn = s;  end
			1: begin cs = -s; sn = c;  end
			2: begin cs = -c; sn = -s; end
			default: begin cs = s; sn = -c; end
		endcase
		al = -u * sn;
		be = u * cs;
		mid = sup <<< 33;
		r.a = 16'(phase_duty(al * 131072 + mid, sup));
		r.b = 16'(phase_duty(113512 * be - al * 65536 + mid, sup));
		r.c = 16'(phase_duty(-al * 65536 - 113512 * be + mid, sup));
		return r;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
		end else begin
			if (!s_tvalid || s_tready) begin
				if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					cmd_t cmd;
					cmd = pending_cmds.pop_front();
					duty_expected.push_back(predict_duty(cmd));
					s_tvalid <= 1'b1;
					s_tdata  <= {4'b0, cmd.ang, cmd.uq};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver readiness
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_cycles > 0) begin
			m_tready <= 1'b0;
			hold_cycles <= hold_cycles - 1;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			duty_t got, want;
			got = m_tdata;
			if (duty_expected.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected transaction: a=%0d b=%0d c=%0d", got.a, got.b, got.c);
			end else begin
				want = duty_expected.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("duty mismatch: exp a=%0d b=%0d c=%0d got a=%0d b=%0d c=%0d",
							want.a, want.b, want.c, got.a, got.b, got.c);
				end
			end
		end
	end

	task automatic apb_write(logic [1:0] idx, logic [31:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			fvm_pkg::REG_SUPPLY: mod_supply = val & 32'h3FFF;
			fvm_pkg::REG_POLES:  mod_poles  = val & 32'h3F;
			fvm_pkg::REG_DIR:    mod_dir    = val & 32'h1;
			default:             mod_zero   = val & 32'hFFF;
		endcase
	endtask

	task automatic settle();
		while (pending_cmds.size() > 0 || duty_expected.size() > 0 || s_tvalid)
			@(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	task automatic set_regs(int sup, int pp, int dr, int za);
		apb_write(fvm_pkg::REG_SUPPLY, sup);
		apb_write(fvm_pkg::REG_POLES, pp);
		apb_write(fvm_pkg::REG_DIR, dr);
		apb_write(fvm_pkg::REG_ZERO, za);
	endtask

	function automatic cmd_t rand_cmd();
		cmd_t c;
		c.ang = 12'($urandom);
		case ($urandom_range(3))
			0: c.uq = 16'($urandom);
			1: c.uq = 16'($signed($urandom_range(12800)) - 16'sd6400);
			2: c.uq = 16'($signed($urandom_range(400)) - 16'sd200);
			default: c.uq = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
		endcase
		return c;
	endfunction

	initial begin
		clk = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		mismatches = 0;
		hold_cycles = 0;
		send_idle_pct = 22;
		recv_idle_pct = 49;
		mod_supply = 12000;
		mod_poles = 7;
		mod_dir = 0;
		mod_zero = 0;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed: field extremes and quadrant boundaries at reset settings
		foreach (ATAN24[i]) begin
			cmd_t c;
			c.uq  = (i % 4 == 0) ? 16'sh7FFF : (i % 4 == 1) ? 16'sh8000 :
				(i % 4 == 2) ? 16'sd0 : 16'sd3000;
			c.ang = (i < 8) ? 12'(i * 512) : 12'(4095 - i);
			pending_cmds.push_back(c);
		end
		settle();
		// supply zero and above the cap, zero and maximum pole counts, reversed direction
		set_regs(0, 0, 1, 4095);
		pending_cmds.push_back(cmd_t'{16'sh8000, 12'd1});
		pending_cmds.push_back(cmd_t'{16'sd1, 12'd4095});
		settle();
		set_regs(16383, 63, 0, 1024);
		pending_cmds.push_back(cmd_t'{16'sh7FFF, 12'd0});
		pending_cmds.push_back(cmd_t'{16'sh8000, 12'd2048});
		pending_cmds.push_back(cmd_t'{16'sd6200, 12'd1365});
		settle();

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: set_regs(12400, 1, 0, 0);
				1: set_regs(1, 32, 1, 2048);
				2: set_regs($urandom_range(1, 12400), $urandom_range(1, 32), 1, $urandom);
				3: set_regs(12000, 7, 0, 0);
				4: set_regs($urandom_range(1, 16383), $urandom_range(0, 63), 0, $urandom);
				default: set_regs(5000, 13, 1, 4095);
			endcase
			if (ph == 2) begin
				send_idle_pct = 49;
				recv_idle_pct = 22;
			end else if (ph == 4) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			for (int k = 0; k < 140; k++)
				pending_cmds.push_back(rand_cmd());
			if (ph == 3) begin
				@(posedge clk);
				hold_cycles <= 200;
			end
			settle();
		end

		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#400000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
